[design/fastcgi_record_parser_top_assert.svh]
// assertion macros for the fastcgi record parser
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef FASTCGI_RECORD_PARSER_TOP_ASSERT_SVH
`define FASTCGI_RECORD_PARSER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FCGI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FCGI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/fcgi_pkg.sv]
// shared types and constants for the fastcgi record parser
// no dependencies
package fcgi_pkg;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_BEGIN  = 4'd1,
        PH_NLEN   = 4'd2,
        PH_VLEN   = 4'd3,
        PH_NAME   = 4'd4,
        PH_VALUE  = 4'd5,
        PH_STDIN  = 4'd6,
        PH_SKIP   = 4'd7,
        PH_PAD    = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        EV_HEADER = 3'd0,
        EV_BEGIN  = 3'd1,
        EV_PAIR   = 3'd2,
        EV_NAME   = 3'd3,
        EV_VALUE  = 3'd4,
        EV_STDIN  = 3'd5,
        EV_TRUNC  = 3'd6,
        EV_NONE   = 3'd7
    } t_event;

    localparam logic [7:0] REC_BEGIN  = 8'd1;
    localparam logic [7:0] REC_PARAMS = 8'd4;
    localparam logic [7:0] REC_STDIN  = 8'd5;

    localparam logic [7:0] TOP_BIT   = 8'h80;
    localparam logic [7:0] LOW_SEVEN = 8'h7f;

    localparam logic [2:0] BEGIN_BODY_BYTES = 3'd3;
    localparam logic [2:0] LONG_LEN_BYTES   = 3'd3;

endpackage

[design/fastcgi_record_parser_top.sv]
// fastcgi record stream parser, one byte per cycle while no result is held waiting
// depends on fcgi_pkg and fastcgi_record_parser_top_assert.svh
//
// channel   direction  handshake                  payload
// in        to block   i_in_valid / o_in_ready    i_stream_byte, i_stream_start
// out       from block o_out_valid / i_out_ready  o_event_kind .. o_record_end
//
// one byte per cycle sustained while no result waits; each result is registered
// the byte goes through an input register, then one pass of the phase logic into
// the result register; bytes that give no event still take their pass
// synchronous active-low reset clears all parser state; i_stream_start restarts in band
// a waiting result holds the pass, the input register still takes one more byte if empty
module fastcgi_record_parser_top
    import fcgi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_stream_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_proto_version,
    output logic [7:0]  o_record_kind,
    output logic [15:0] o_request_number,
    output logic [15:0] o_body_length,
    output logic [7:0]  o_pad_length,
    output logic [15:0] o_app_role,
    output logic [7:0]  o_begin_flags,
    output logic [30:0] o_name_length,
    output logic [30:0] o_value_length,
    output logic [7:0]  o_payload_byte,
    output logic        o_record_end
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;

    // parser state
    t_phase      r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [63:0] r_hdr, n_hdr;
    logic [15:0] r_content, n_content;
    logic [7:0]  r_pad, n_pad;
    logic [30:0] r_gather, n_gather;
    logic [30:0] r_name, n_name;
    logic [30:0] r_value, n_value;

    // result register
    logic        r_out_valid;
    logic [2:0]  r_ev_kind;
    logic [63:0] r_ev_hdr;
    logic [15:0] r_ev_role;
    logic [7:0]  r_ev_flags;
    logic [30:0] r_ev_nlen;
    logic [30:0] r_ev_vlen;
    logic [7:0]  r_ev_payload;
    logic        r_ev_end;

    // state as seen by the current byte, after an in-band restart
    t_phase      c_phase;
    logic [2:0]  c_pos;
    logic [63:0] c_hdr;
    logic [15:0] c_content;
    logic [7:0]  c_pad;
    logic [30:0] c_gather;
    logic [30:0] c_name;
    logic [30:0] c_value;

    logic        w_fire;
    logic [2:0]  w_pos_inc;
    logic [2:0]  w_pos_dec;
    logic [23:0] w_begin_word;
    logic [30:0] w_gather_word;
    logic [2:0]  w_gather_pos;
    logic        w_gather_done;
    logic        w_in_content;
    logic        w_content_end;
    logic        w_pair_done;
    t_phase      w_mid_phase;
    logic [30:0] w_name_mid;
    logic [30:0] w_value_mid;
    logic        w_hdr_done;
    logic        w_pad_done;
    logic        w_content_phase;

    t_event      w_ev_kind;
    logic        w_ev_valid;
    logic [15:0] w_ev_role;
    logic [7:0]  w_ev_flags;
    logic [30:0] w_ev_nlen;
    logic [30:0] w_ev_vlen;
    logic [7:0]  w_ev_payload;
    logic        w_ev_end;

    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    assign c_phase   = r_in_start ? PH_HEADER : r_phase;
    assign c_pos     = r_in_start ? 3'd0 : r_pos;
    assign c_hdr     = r_in_start ? 64'd0 : r_hdr;
    assign c_content = r_in_start ? 16'd0 : r_content;
    assign c_pad     = r_in_start ? 8'd0 : r_pad;
    assign c_gather  = r_in_start ? 31'd0 : r_gather;
    assign c_name    = r_in_start ? 31'd0 : r_name;
    assign c_value   = r_in_start ? 31'd0 : r_value;

    assign w_pos_inc    = c_pos + 3'd1;
    assign w_pos_dec    = c_pos - 3'd1;
    assign w_begin_word = {c_gather[15:0], r_in_byte};

    // pair length byte: one byte, or four with the top bit set, high byte first
    always_comb begin
        w_gather_word = c_gather;
        w_gather_pos  = c_pos;
        w_gather_done = 1'b0;
        if (c_pos == 3'd0) begin
            if ((r_in_byte & TOP_BIT) != 8'd0) begin
                w_gather_word = {r_in_byte[6:0] & LOW_SEVEN[6:0], 24'd0};
                w_gather_pos  = LONG_LEN_BYTES;
            end else begin
                w_gather_word = {23'd0, r_in_byte};
                w_gather_done = 1'b1;
            end
        end else begin
            unique case (w_pos_dec[1:0])
                2'd0: w_gather_word = c_gather | {23'd0, r_in_byte};
                2'd1: w_gather_word = c_gather | {15'd0, r_in_byte, 8'd0};
                2'd2: w_gather_word = c_gather | {7'd0, r_in_byte, 16'd0};
                default: w_gather_word = c_gather | {r_in_byte[6:0], 24'd0};
            endcase
            w_gather_pos  = w_pos_dec;
            w_gather_done = (w_pos_dec == 3'd0);
        end
    end

    // next state
    always_comb begin
        n_phase      = c_phase;
        n_pos        = c_pos;
        n_hdr        = c_hdr;
        n_content    = c_content;
        n_pad        = c_pad;
        n_gather     = c_gather;
        n_name       = c_name;
        n_value      = c_value;
        w_in_content = 1'b0;
        w_pair_done  = 1'b0;
        w_hdr_done   = 1'b0;
        w_pad_done   = 1'b0;

        unique case (c_phase)
            PH_BEGIN: begin
                w_in_content = 1'b1;
                n_gather     = {7'd0, w_begin_word};
                n_pos        = w_pos_inc;
                if (w_pos_inc >= BEGIN_BODY_BYTES) begin
                    n_phase = PH_SKIP;
                end
            end
            PH_NLEN: begin
                w_in_content = 1'b1;
                n_gather     = w_gather_word;
                n_pos        = w_gather_pos;
                if (w_gather_done) begin
                    n_name   = w_gather_word;
                    n_gather = 31'd0;
                    n_phase  = PH_VLEN;
                end
            end
            PH_VLEN: begin
                w_in_content = 1'b1;
                n_gather     = w_gather_word;
                n_pos        = w_gather_pos;
                if (w_gather_done) begin
                    n_value  = w_gather_word;
                    n_gather = 31'd0;
                    priority if (c_name != 31'd0) begin
                        n_phase = PH_NAME;
                    end else if (w_gather_word != 31'd0) begin
                        n_phase = PH_VALUE;
                    end else begin
                        n_phase     = PH_NLEN;
                        w_pair_done = 1'b1;
                    end
                end
            end
            PH_NAME: begin
                w_in_content = 1'b1;
                n_name       = c_name - 31'd1;
                if (n_name == 31'd0) begin
                    if (c_value != 31'd0) begin
                        n_phase = PH_VALUE;
                    end else begin
                        n_phase     = PH_NLEN;
                        w_pair_done = 1'b1;
                    end
                end
            end
            PH_VALUE: begin
                w_in_content = 1'b1;
                n_value      = c_value - 31'd1;
                if (n_value == 31'd0) begin
                    n_phase     = PH_NLEN;
                    w_pair_done = 1'b1;
                end
            end
            PH_STDIN, PH_SKIP: begin
                w_in_content = 1'b1;
            end
            PH_PAD: begin
                n_pad = c_pad - 8'd1;
                if (n_pad == 8'd0) begin
                    n_phase    = PH_HEADER;
                    w_pad_done = 1'b1;
                end
            end
            default: begin
                n_hdr   = {c_hdr[55:0], r_in_byte};
                n_pos   = w_pos_inc;
                n_phase = PH_HEADER;
                if (w_pos_inc == 3'd0) begin
                    w_hdr_done = 1'b1;
                    n_content  = n_hdr[31:16];
                    n_pad      = n_hdr[15:8];
                    n_gather   = 31'd0;
                    n_name     = 31'd0;
                    n_value    = 31'd0;
                    priority if (n_hdr[31:16] == 16'd0) begin
                        n_phase = (n_hdr[15:8] != 8'd0) ? PH_PAD : PH_HEADER;
                    end else if (n_hdr[55:48] == REC_BEGIN) begin
                        n_phase = PH_BEGIN;
                    end else if (n_hdr[55:48] == REC_PARAMS) begin
                        n_phase = PH_NLEN;
                    end else if (n_hdr[55:48] == REC_STDIN) begin
                        n_phase = PH_STDIN;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
        endcase

        w_mid_phase   = n_phase;
        w_name_mid    = n_name;
        w_value_mid   = n_value;
        w_content_end = 1'b0;

        if (w_in_content) begin
            n_content = c_content - 16'd1;
            if (n_content == 16'd0) begin
                w_content_end = 1'b1;
                n_pos         = 3'd0;
                n_gather      = 31'd0;
                n_name        = 31'd0;
                n_value       = 31'd0;
                n_phase       = (c_pad != 8'd0) ? PH_PAD : PH_HEADER;
            end
        end
    end

    // event for the current byte
    always_comb begin
        w_ev_kind    = EV_NONE;
        w_ev_role    = 16'd0;
        w_ev_flags   = 8'd0;
        w_ev_nlen    = 31'd0;
        w_ev_vlen    = 31'd0;
        w_ev_payload = 8'd0;
        w_ev_end     = 1'b0;

        unique case (c_phase)
            PH_BEGIN: begin
                if (w_pos_inc >= BEGIN_BODY_BYTES) begin
                    w_ev_kind  = EV_BEGIN;
                    w_ev_role  = w_begin_word[23:8];
                    w_ev_flags = w_begin_word[7:0];
                end
            end
            PH_VLEN: begin
                if (w_gather_done) begin
                    w_ev_kind = EV_PAIR;
                    w_ev_nlen = c_name;
                    w_ev_vlen = w_gather_word;
                end
            end
            PH_NAME: begin
                w_ev_kind    = EV_NAME;
                w_ev_payload = r_in_byte;
            end
            PH_VALUE: begin
                w_ev_kind    = EV_VALUE;
                w_ev_payload = r_in_byte;
            end
            PH_STDIN: begin
                w_ev_kind    = EV_STDIN;
                w_ev_payload = r_in_byte;
            end
            PH_PAD: begin
                w_ev_end = w_pad_done;
            end
            PH_NLEN, PH_SKIP: begin
                w_ev_kind = EV_NONE;
            end
            default: begin
                if (w_hdr_done) begin
                    w_ev_kind = EV_HEADER;
                    w_ev_end  = (n_hdr[31:16] == 16'd0) && (n_hdr[15:8] == 8'd0);
                end
            end
        endcase

        if (w_content_end) begin
            w_ev_end = (c_pad == 8'd0);
            // params content ran out in the middle of a pair
            if ((w_mid_phase == PH_NLEN || w_mid_phase == PH_VLEN ||
                 w_mid_phase == PH_NAME || w_mid_phase == PH_VALUE) && !w_pair_done) begin
                w_ev_kind    = EV_TRUNC;
                w_ev_payload = r_in_byte;
                w_ev_nlen    = w_name_mid;
                w_ev_vlen    = w_value_mid;
                w_ev_role    = 16'd0;
                w_ev_flags   = 8'd0;
            end
        end

        w_ev_valid = (w_ev_kind != EV_NONE) || w_ev_end;
        // a silent byte that closes the record repeats the header
        if (w_ev_kind == EV_NONE) begin
            w_ev_kind = EV_HEADER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_byte  <= i_stream_byte;
            r_in_start <= i_stream_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_pos     <= 3'd0;
            r_hdr     <= 64'd0;
            r_content <= 16'd0;
            r_pad     <= 8'd0;
            r_gather  <= 31'd0;
            r_name    <= 31'd0;
            r_value   <= 31'd0;
        end else if (w_fire) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_hdr     <= n_hdr;
            r_content <= n_content;
            r_pad     <= n_pad;
            r_gather  <= n_gather;
            r_name    <= n_name;
            r_value   <= n_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_ev_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_ev_valid) begin
            r_ev_kind    <= w_ev_kind;
            r_ev_hdr     <= n_hdr;
            r_ev_role    <= w_ev_role;
            r_ev_flags   <= w_ev_flags;
            r_ev_nlen    <= w_ev_nlen;
            r_ev_vlen    <= w_ev_vlen;
            r_ev_payload <= w_ev_payload;
            r_ev_end     <= w_ev_end;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_kind     = r_ev_kind;
    assign o_proto_version  = r_ev_hdr[63:56];
    assign o_record_kind    = r_ev_hdr[55:48];
    assign o_request_number = r_ev_hdr[47:32];
    assign o_body_length    = r_ev_hdr[31:16];
    assign o_pad_length     = r_ev_hdr[15:8];
    assign o_app_role       = r_ev_role;
    assign o_begin_flags    = r_ev_flags;
    assign o_name_length    = r_ev_nlen;
    assign o_value_length   = r_ev_vlen;
    assign o_payload_byte   = r_ev_payload;
    assign o_record_end     = r_ev_end;

    assign w_content_phase = (r_phase == PH_BEGIN) || (r_phase == PH_NLEN) ||
                             (r_phase == PH_VLEN) || (r_phase == PH_NAME) ||
                             (r_phase == PH_VALUE) || (r_phase == PH_STDIN) ||
                             (r_phase == PH_SKIP);

`include "fastcgi_record_parser_top_assert.svh"

    `FCGI_ASSERT_NOW(a_pad_live, r_phase == PH_PAD, r_pad != 8'd0, "pad phase with no pad left")
    `FCGI_ASSERT_NOW(a_content_live, w_content_phase, r_content != 16'd0, "content phase, none left")
    `FCGI_ASSERT_NEXT(a_silent_byte, w_fire && !w_ev_valid, !r_out_valid, "no-event byte gave result")
    `FCGI_ASSERT_NEXT(a_in_held, r_in_valid && !w_fire, r_in_valid, "stalled request lost")

endmodule
